### rtl/core/m3ls_pkg.sv
package m3ls_pkg;

   // default widths
   localparam int FRAC_BITS_DEF = 16;
   localparam int WORD_BITS_DEF = 32;
   localparam int ACC_BITS      = 64;
   localparam int STEP_BITS     = 5;
   localparam int SEL_BITS      = 5;

   typedef logic signed [ACC_BITS-1:0] acc_type;
   typedef logic [STEP_BITS-1:0]       step_type;
   typedef logic [SEL_BITS-1:0]        sel_type;

   // symmetric limit of the wide intermediates
   localparam acc_type ACC_LIM = 64'sh7FFF_FFFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_SOLVE3 = 2'd1,
      CMD_SOLVE2 = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   localparam logic [1:0] ROW_NONE = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_START,
      ST_MUL_WAIT,
      ST_CHECK,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_ADD,
      OP_SUB
   } op_type;

   // operand and destination codes
   localparam sel_type SEL_M0  = 5'd0;
   localparam sel_type SEL_M1  = 5'd1;
   localparam sel_type SEL_M2  = 5'd2;
   localparam sel_type SEL_M3  = 5'd3;
   localparam sel_type SEL_M4  = 5'd4;
   localparam sel_type SEL_M5  = 5'd5;
   localparam sel_type SEL_M6  = 5'd6;
   localparam sel_type SEL_M7  = 5'd7;
   localparam sel_type SEL_M8  = 5'd8;
   localparam sel_type SEL_B0  = 5'd9;
   localparam sel_type SEL_B1  = 5'd10;
   localparam sel_type SEL_B2  = 5'd11;
   localparam sel_type SEL_C00 = 5'd12;
   localparam sel_type SEL_C01 = 5'd13;
   localparam sel_type SEL_C02 = 5'd14;
   localparam sel_type SEL_C10 = 5'd15;
   localparam sel_type SEL_C11 = 5'd16;
   localparam sel_type SEL_C12 = 5'd17;
   localparam sel_type SEL_C20 = 5'd18;
   localparam sel_type SEL_C21 = 5'd19;
   localparam sel_type SEL_C22 = 5'd20;
   localparam sel_type SEL_DET = 5'd21;
   localparam sel_type SEL_N0  = 5'd22;
   localparam sel_type SEL_N1  = 5'd23;
   localparam sel_type SEL_N2  = 5'd24;

   typedef struct packed {
      sel_type a_sel;
      sel_type b_sel;
      op_type  op;
      logic    wr;
      sel_type dst;
      logic    last;
   } uop_type;

   typedef struct packed {
      logic    done;
      logic    clip;
      acc_type value;
   } arith_rsp_type;

   function automatic uop_type mk(sel_type a, sel_type b, op_type op, logic wr,
                                  sel_type dst, logic last);
      uop_type u;
      u.a_sel = a;
      u.b_sel = b;
      u.op    = op;
      u.wr    = wr;
      u.dst   = dst;
      u.last  = last;
      return u;
   endfunction

   // microprogram: one wide product per step, folded into the accumulator
   function automatic uop_type uop_fetch(logic solve3, step_type step);
      uop_type u;
      u = mk(SEL_M0, SEL_M0, OP_LOAD, 1'b0, SEL_DET, 1'b1);
      if (!solve3) begin
         case (step)
            5'd0: u = mk(SEL_M0, SEL_M4, OP_LOAD, 1'b0, SEL_DET, 1'b0);
            5'd1: u = mk(SEL_M1, SEL_M3, OP_SUB,  1'b1, SEL_DET, 1'b0);
            5'd2: u = mk(SEL_M4, SEL_B0, OP_LOAD, 1'b0, SEL_N0,  1'b0);
            5'd3: u = mk(SEL_M1, SEL_B1, OP_SUB,  1'b1, SEL_N0,  1'b0);
            5'd4: u = mk(SEL_M0, SEL_B1, OP_LOAD, 1'b0, SEL_N1,  1'b0);
            5'd5: u = mk(SEL_M3, SEL_B0, OP_SUB,  1'b1, SEL_N1,  1'b1);
            default: u = mk(SEL_M0, SEL_M0, OP_LOAD, 1'b0, SEL_DET, 1'b1);
         endcase
      end else begin
         case (step)
            5'd0:  u = mk(SEL_M4, SEL_M8, OP_LOAD, 1'b0, SEL_C00, 1'b0);
            5'd1:  u = mk(SEL_M5, SEL_M7, OP_SUB,  1'b1, SEL_C00, 1'b0);
            5'd2:  u = mk(SEL_M7, SEL_M2, OP_LOAD, 1'b0, SEL_C01, 1'b0);
            5'd3:  u = mk(SEL_M1, SEL_M8, OP_SUB,  1'b1, SEL_C01, 1'b0);
            5'd4:  u = mk(SEL_M1, SEL_M5, OP_LOAD, 1'b0, SEL_C02, 1'b0);
            5'd5:  u = mk(SEL_M4, SEL_M2, OP_SUB,  1'b1, SEL_C02, 1'b0);
            5'd6:  u = mk(SEL_M6, SEL_M5, OP_LOAD, 1'b0, SEL_C10, 1'b0);
            5'd7:  u = mk(SEL_M3, SEL_M8, OP_SUB,  1'b1, SEL_C10, 1'b0);
            5'd8:  u = mk(SEL_M0, SEL_M8, OP_LOAD, 1'b0, SEL_C11, 1'b0);
            5'd9:  u = mk(SEL_M6, SEL_M2, OP_SUB,  1'b1, SEL_C11, 1'b0);
            5'd10: u = mk(SEL_M3, SEL_M2, OP_LOAD, 1'b0, SEL_C12, 1'b0);
            5'd11: u = mk(SEL_M0, SEL_M5, OP_SUB,  1'b1, SEL_C12, 1'b0);
            5'd12: u = mk(SEL_M3, SEL_M7, OP_LOAD, 1'b0, SEL_C20, 1'b0);
            5'd13: u = mk(SEL_M6, SEL_M4, OP_SUB,  1'b1, SEL_C20, 1'b0);
            5'd14: u = mk(SEL_M6, SEL_M1, OP_LOAD, 1'b0, SEL_C21, 1'b0);
            5'd15: u = mk(SEL_M0, SEL_M7, OP_SUB,  1'b1, SEL_C21, 1'b0);
            5'd16: u = mk(SEL_M0, SEL_M4, OP_LOAD, 1'b0, SEL_C22, 1'b0);
            5'd17: u = mk(SEL_M3, SEL_M1, OP_SUB,  1'b1, SEL_C22, 1'b0);
            5'd18: u = mk(SEL_M0, SEL_C00, OP_LOAD, 1'b0, SEL_DET, 1'b0);
            5'd19: u = mk(SEL_M3, SEL_C01, OP_ADD,  1'b0, SEL_DET, 1'b0);
            5'd20: u = mk(SEL_M6, SEL_C02, OP_ADD,  1'b1, SEL_DET, 1'b0);
            5'd21: u = mk(SEL_C00, SEL_B0, OP_LOAD, 1'b0, SEL_N0, 1'b0);
            5'd22: u = mk(SEL_C01, SEL_B1, OP_ADD,  1'b0, SEL_N0, 1'b0);
            5'd23: u = mk(SEL_C02, SEL_B2, OP_ADD,  1'b1, SEL_N0, 1'b0);
            5'd24: u = mk(SEL_C10, SEL_B0, OP_LOAD, 1'b0, SEL_N1, 1'b0);
            5'd25: u = mk(SEL_C11, SEL_B1, OP_ADD,  1'b0, SEL_N1, 1'b0);
            5'd26: u = mk(SEL_C12, SEL_B2, OP_ADD,  1'b1, SEL_N1, 1'b0);
            5'd27: u = mk(SEL_C20, SEL_B0, OP_LOAD, 1'b0, SEL_N2, 1'b0);
            5'd28: u = mk(SEL_C21, SEL_B1, OP_ADD,  1'b0, SEL_N2, 1'b0);
            5'd29: u = mk(SEL_C22, SEL_B2, OP_ADD,  1'b1, SEL_N2, 1'b1);
            default: u = mk(SEL_M0, SEL_M0, OP_LOAD, 1'b0, SEL_DET, 1'b1);
         endcase
      end
      return u;
   endfunction

endpackage

### rtl/core/m3ls_req_if.sv
interface m3ls_req_if #(
   parameter int WordBits = m3ls_pkg::WORD_BITS_DEF
);
   logic                       valid;
   logic                       ready;
   logic [1:0]                 cmd;
   logic [1:0]                 row;
   logic signed [WordBits-1:0] value_a;
   logic signed [WordBits-1:0] value_b;
   logic signed [WordBits-1:0] value_c;

   modport source (output valid, cmd, row, value_a, value_b, value_c, input ready);
   modport sink   (input valid, cmd, row, value_a, value_b, value_c, output ready);
endinterface

### rtl/core/m3ls_rsp_if.sv
interface m3ls_rsp_if #(
   parameter int WordBits = m3ls_pkg::WORD_BITS_DEF
);
   logic                       valid;
   logic                       ready;
   logic signed [WordBits-1:0] sol_x;
   logic signed [WordBits-1:0] sol_y;
   logic signed [WordBits-1:0] sol_z;
   logic signed [WordBits-1:0] det_out;
   logic                       singular;
   logic                       saturated;

   modport source (output valid, sol_x, sol_y, sol_z, det_out, singular, saturated,
                   input ready);
   modport sink   (input valid, sol_x, sol_y, sol_z, det_out, singular, saturated,
                   output ready);
endinterface

### rtl/core/m3ls_mulq.sv
module m3ls_mulq #(
   parameter int FRAC_BITS = m3ls_pkg::FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  m3ls_pkg::acc_type       a,
   input  m3ls_pkg::acc_type       b,
   output m3ls_pkg::arith_rsp_type rsp
);
   import m3ls_pkg::*;

   localparam logic [127:0] HALF = 128'd1 << (FRAC_BITS - 1);

   logic         busy_ff, busy_in;
   logic [2:0]   ph_ff, ph_in;
   logic [63:0]  am_ff, am_in, bm_ff, bm_in;
   logic         neg_ff, neg_in;
   logic [127:0] prod_ff, prod_in;
   arith_rsp_type rsp_ff, rsp_in;

   logic [31:0]  pa, pb;
   logic [63:0]  pp;
   logic [127:0] pp_sh, rnd, qw;
   logic [62:0]  mag;
   logic         ovf;

   // one 32x32 partial product per cycle, then round and clip
   always_comb begin
      busy_in = busy_ff;
      ph_in   = ph_ff;
      am_in   = am_ff;
      bm_in   = bm_ff;
      neg_in  = neg_ff;
      prod_in = prod_ff;
      rsp_in  = '0;
      rsp_in.value = rsp_ff.value;
      rsp_in.clip  = rsp_ff.clip;

      case (ph_ff[1:0])
         2'd0:    begin pa = am_ff[31:0];  pb = bm_ff[31:0];  end
         2'd1:    begin pa = am_ff[31:0];  pb = bm_ff[63:32]; end
         2'd2:    begin pa = am_ff[63:32]; pb = bm_ff[31:0];  end
         default: begin pa = am_ff[63:32]; pb = bm_ff[63:32]; end
      endcase
      pp = pa * pb;
      case (ph_ff[1:0])
         2'd0:    pp_sh = {64'd0, pp};
         2'd3:    pp_sh = {pp, 64'd0};
         default: pp_sh = {32'd0, pp, 32'd0};
      endcase

      rnd = prod_ff + HALF;
      qw  = rnd >> FRAC_BITS;
      ovf = |qw[127:63];
      mag = qw[62:0];

      if (start) begin
         busy_in = 1'b1;
         ph_in   = 3'd0;
         am_in   = a[63] ? 64'(-a) : 64'(a);
         bm_in   = b[63] ? 64'(-b) : 64'(b);
         neg_in  = a[63] ^ b[63];
         prod_in = '0;
      end else if (busy_ff) begin
         if (ph_ff == 3'd4) begin
            busy_in     = 1'b0;
            rsp_in.done = 1'b1;
            rsp_in.clip = ovf;
            if (ovf) begin
               rsp_in.value = neg_ff ? -ACC_LIM : ACC_LIM;
            end else begin
               rsp_in.value = neg_ff ? -acc_type'({1'b0, mag}) : acc_type'({1'b0, mag});
            end
         end else begin
            prod_in = prod_ff + pp_sh;
            ph_in   = ph_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         rsp_ff.done <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         rsp_ff.done <= rsp_in.done;
      end
      ph_ff        <= ph_in;
      am_ff        <= am_in;
      bm_ff        <= bm_in;
      neg_ff       <= neg_in;
      prod_ff      <= prod_in;
      rsp_ff.clip  <= rsp_in.clip;
      rsp_ff.value <= rsp_in.value;
   end

   assign rsp = rsp_ff;

endmodule

### rtl/core/m3ls_div.sv
module m3ls_div #(
   parameter int FRAC_BITS = m3ls_pkg::FRAC_BITS_DEF,
   parameter int WORD_BITS = m3ls_pkg::WORD_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  m3ls_pkg::acc_type       num,
   input  m3ls_pkg::acc_type       den,
   output m3ls_pkg::arith_rsp_type rsp
);
   import m3ls_pkg::*;

   localparam int ITERS = 64 + FRAC_BITS;
   localparam int CNT_W = $clog2(ITERS + 1);
   localparam logic [63:0] LIM_NEG = 64'd1 << (WORD_BITS - 1);
   localparam logic [63:0] LIM_POS = LIM_NEG - 64'd1;

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0]      ud_ff, ud_in, dvd_ff, dvd_in, r_ff, r_in, q_ff, q_in;
   logic             ovf_ff, ovf_in, neg_ff, neg_in;
   arith_rsp_type    rsp_ff, rsp_in;

   logic [64:0] rs, qinc;
   logic        ge, rnd, clip;
   logic [63:0] lim, mag;

   // restoring division, one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      ud_in   = ud_ff;
      dvd_in  = dvd_ff;
      r_in    = r_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      neg_in  = neg_ff;
      rsp_in  = '0;
      rsp_in.value = rsp_ff.value;
      rsp_in.clip  = rsp_ff.clip;

      rs   = {r_ff, dvd_ff[63]};
      ge   = rs >= {1'b0, ud_ff};
      rnd  = r_ff >= (ud_ff - r_ff);
      qinc = {1'b0, q_ff} + 65'(rnd);
      lim  = neg_ff ? LIM_NEG : LIM_POS;
      clip = ovf_ff || qinc[64] || (qinc[63:0] > lim);
      mag  = clip ? lim : qinc[63:0];

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         ud_in   = den[63] ? 64'(-den) : 64'(den);
         dvd_in  = num[63] ? 64'(-num) : 64'(num);
         r_in    = '0;
         q_in    = '0;
         ovf_in  = 1'b0;
         neg_in  = num[63] ^ den[63];
      end else if (busy_ff) begin
         if (cnt_ff == CNT_W'(ITERS)) begin
            busy_in      = 1'b0;
            rsp_in.done  = 1'b1;
            rsp_in.clip  = clip;
            rsp_in.value = neg_ff ? -acc_type'(mag) : acc_type'(mag);
         end else begin
            r_in   = ge ? 64'(rs - {1'b0, ud_ff}) : rs[63:0];
            q_in   = {q_ff[62:0], ge};
            ovf_in = ovf_ff | q_ff[63];
            dvd_in = {dvd_ff[62:0], 1'b0};
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         rsp_ff.done <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         rsp_ff.done <= rsp_in.done;
      end
      cnt_ff       <= cnt_in;
      ud_ff        <= ud_in;
      dvd_ff       <= dvd_in;
      r_ff         <= r_in;
      q_ff         <= q_in;
      ovf_ff       <= ovf_in;
      neg_ff       <= neg_in;
      rsp_ff.clip  <= rsp_in.clip;
      rsp_ff.value <= rsp_in.value;
   end

   assign rsp = rsp_ff;

endmodule

### rtl/core/matrix3_linear_solve.sv
// channel  port    direction  word
// request  req_ch  in         cmd, row, value_a, value_b, value_c
// response rsp_ch  out        sol_x, sol_y, sol_z, det_out, singular, saturated
//
// a solve runs 30 (3x3) or 6 (2x2) wide products through one shared multiplier,
// then 3 or 2 quotients (none for a zero determinant) through one shared divider,
// with a state each to take the word, check the determinant and hand off the result.
// synchronous reset clears the matrix and the control state.
// a new word is taken while the result waits; a second result stalls until it is taken.
module matrix3_linear_solve #(
   parameter int FRAC_BITS = m3ls_pkg::FRAC_BITS_DEF,
   parameter int WORD_BITS = m3ls_pkg::WORD_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   m3ls_req_if.sink   req_ch,
   m3ls_rsp_if.source rsp_ch
);
   import m3ls_pkg::*;

   typedef logic signed [WORD_BITS-1:0] word_type;

   localparam acc_type WORD_HI = acc_type'((64'sd1 <<< (WORD_BITS - 1)) - 64'sd1);
   localparam acc_type WORD_LO = -WORD_HI - 64'sd1;
   localparam logic signed [64:0] SUM_HI = {1'b0, ACC_LIM};
   localparam logic signed [64:0] SUM_LO = -SUM_HI;

   state_type state_ff, state_in;

   word_type m_ff [9];
   word_type m_in [9];
   word_type b_ff [3];
   word_type b_in [3];
   acc_type  cof_ff [9];
   acc_type  cof_in [9];
   acc_type  num_ff [3];
   acc_type  num_in [3];
   word_type qres_ff [3];
   word_type qres_in [3];
   acc_type  det_ff, det_in, acc_ff, acc_in;
   logic     solve3_ff, solve3_in, clip_ff, clip_in, sing_ff, sing_in;
   step_type step_ff, step_in;
   logic [1:0] qidx_ff, qidx_in;
   word_type dout_ff, dout_in;

   word_type o_x_ff, o_x_in, o_y_ff, o_y_in, o_z_ff, o_z_in, o_det_ff, o_det_in;
   logic     o_sing_ff, o_sing_in, o_sat_ff, o_sat_in, o_valid_ff, o_valid_in;

   uop_type       uop;
   acc_type       opa, opb;
   arith_rsp_type mul_rsp, div_rsp;
   logic          mul_start, div_start, req_ready, accept, out_free;
   logic signed [64:0] sum;
   acc_type       sumv, prodv;
   logic          sumclip;
   logic [1:0]    qlast;

   function automatic acc_type operand(sel_type sel, word_type m [9], word_type b [3],
                                       acc_type c [9], acc_type d, acc_type n [3]);
      acc_type v;
      v = '0;
      case (sel)
         SEL_M0:  v = acc_type'(m[0]);
         SEL_M1:  v = acc_type'(m[1]);
         SEL_M2:  v = acc_type'(m[2]);
         SEL_M3:  v = acc_type'(m[3]);
         SEL_M4:  v = acc_type'(m[4]);
         SEL_M5:  v = acc_type'(m[5]);
         SEL_M6:  v = acc_type'(m[6]);
         SEL_M7:  v = acc_type'(m[7]);
         SEL_M8:  v = acc_type'(m[8]);
         SEL_B0:  v = acc_type'(b[0]);
         SEL_B1:  v = acc_type'(b[1]);
         SEL_B2:  v = acc_type'(b[2]);
         SEL_C00: v = c[0];
         SEL_C01: v = c[1];
         SEL_C02: v = c[2];
         SEL_C10: v = c[3];
         SEL_C11: v = c[4];
         SEL_C12: v = c[5];
         SEL_C20: v = c[6];
         SEL_C21: v = c[7];
         SEL_C22: v = c[8];
         SEL_DET: v = d;
         SEL_N0:  v = n[0];
         SEL_N1:  v = n[1];
         SEL_N2:  v = n[2];
         default: v = '0;
      endcase
      return v;
   endfunction

   // current microinstruction and its operands
   assign uop   = uop_fetch(solve3_ff, step_ff);
   assign opa   = operand(uop.a_sel, m_ff, b_ff, cof_ff, det_ff, num_ff);
   assign opb   = operand(uop.b_sel, m_ff, b_ff, cof_ff, det_ff, num_ff);
   assign qlast = solve3_ff ? 2'd2 : 2'd1;

   assign accept   = req_ch.valid && req_ready;
   assign out_free = !o_valid_ff || rsp_ch.ready;

   m3ls_mulq #(.FRAC_BITS(FRAC_BITS)) u_mulq (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (opa),
      .b     (opb),
      .rsp   (mul_rsp)
   );

   m3ls_div #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff[qidx_ff]),
      .den   (det_ff),
      .rsp   (div_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_ch.cmd == CMD_SOLVE3 || req_ch.cmd == CMD_SOLVE2)) begin
               state_in = ST_MUL_START;
            end
         end
         ST_MUL_START: state_in = ST_MUL_WAIT;
         ST_MUL_WAIT: begin
            if (mul_rsp.done) begin
               state_in = uop.last ? ST_CHECK : ST_MUL_START;
            end
         end
         ST_CHECK: state_in = (det_ff == '0) ? ST_FIN : ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = (qidx_ff == qlast) ? ST_FIN : ST_DIV_START;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = 1'b0;
      mul_start = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE:      req_ready = 1'b1;
         ST_MUL_START: mul_start = 1'b1;
         ST_DIV_START: div_start = 1'b1;
         default: ;
      endcase
   end

   // saturating accumulate of the returned product
   always_comb begin
      prodv = (uop.op == OP_SUB) ? -mul_rsp.value : mul_rsp.value;
      sum   = {acc_ff[63], acc_ff} + {prodv[63], prodv};
      sumclip = 1'b0;
      if (uop.op == OP_LOAD) begin
         sumv = mul_rsp.value;
      end else if (sum > SUM_HI) begin
         sumv = ACC_LIM;
         sumclip = 1'b1;
      end else if (sum < SUM_LO) begin
         sumv = -ACC_LIM;
         sumclip = 1'b1;
      end else begin
         sumv = sum[63:0];
      end
   end

   // datapath
   always_comb begin
      m_in      = m_ff;
      b_in      = b_ff;
      cof_in    = cof_ff;
      num_in    = num_ff;
      qres_in   = qres_ff;
      det_in    = det_ff;
      acc_in    = acc_ff;
      solve3_in = solve3_ff;
      clip_in   = clip_ff;
      sing_in   = sing_ff;
      step_in   = step_ff;
      qidx_in   = qidx_ff;
      dout_in   = dout_ff;
      o_x_in    = o_x_ff;
      o_y_in    = o_y_ff;
      o_z_in    = o_z_ff;
      o_det_in  = o_det_ff;
      o_sing_in = o_sing_ff;
      o_sat_in  = o_sat_ff;
      o_valid_in = o_valid_ff && !rsp_ch.ready;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_ch.cmd == CMD_LOAD && req_ch.row != ROW_NONE) begin
                  m_in[4'(req_ch.row) * 4'd3]         = req_ch.value_a;
                  m_in[4'(req_ch.row) * 4'd3 + 4'd1]  = req_ch.value_b;
                  m_in[4'(req_ch.row) * 4'd3 + 4'd2]  = req_ch.value_c;
               end
               b_in[0]   = req_ch.value_a;
               b_in[1]   = req_ch.value_b;
               b_in[2]   = req_ch.value_c;
               solve3_in = (req_ch.cmd == CMD_SOLVE3);
               clip_in   = 1'b0;
               step_in   = '0;
               qidx_in   = '0;
               dout_in   = '0;
               sing_in   = 1'b0;
               for (int i = 0; i < 3; i++) begin
                  qres_in[i] = '0;
               end
            end
         end
         ST_MUL_WAIT: begin
            if (mul_rsp.done) begin
               acc_in  = sumv;
               clip_in = clip_ff | mul_rsp.clip | sumclip;
               step_in = step_ff + 5'd1;
               if (uop.wr) begin
                  case (uop.dst)
                     SEL_C00: cof_in[0] = sumv;
                     SEL_C01: cof_in[1] = sumv;
                     SEL_C02: cof_in[2] = sumv;
                     SEL_C10: cof_in[3] = sumv;
                     SEL_C11: cof_in[4] = sumv;
                     SEL_C12: cof_in[5] = sumv;
                     SEL_C20: cof_in[6] = sumv;
                     SEL_C21: cof_in[7] = sumv;
                     SEL_C22: cof_in[8] = sumv;
                     SEL_DET: det_in    = sumv;
                     SEL_N0:  num_in[0] = sumv;
                     SEL_N1:  num_in[1] = sumv;
                     SEL_N2:  num_in[2] = sumv;
                     default: ;
                  endcase
               end
            end
         end
         ST_CHECK: begin
            if (det_ff == '0) begin
               sing_in = 1'b1;
            end else if (det_ff > WORD_HI) begin
               dout_in = word_type'(WORD_HI);
               clip_in = 1'b1;
            end else if (det_ff < WORD_LO) begin
               dout_in = word_type'(WORD_LO);
               clip_in = 1'b1;
            end else begin
               dout_in = det_ff[WORD_BITS-1:0];
            end
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               qres_in[qidx_ff] = div_rsp.value[WORD_BITS-1:0];
               clip_in = clip_ff | div_rsp.clip;
               qidx_in = qidx_ff + 2'd1;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               o_x_in     = qres_ff[0];
               o_y_in     = qres_ff[1];
               o_z_in     = qres_ff[2];
               o_det_in   = dout_ff;
               o_sing_in  = sing_ff;
               o_sat_in   = clip_ff;
               o_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         o_valid_ff <= 1'b0;
         for (int i = 0; i < 9; i++) begin
            m_ff[i] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         o_valid_ff <= o_valid_in;
         m_ff       <= m_in;
      end
      b_ff      <= b_in;
      cof_ff    <= cof_in;
      num_ff    <= num_in;
      qres_ff   <= qres_in;
      det_ff    <= det_in;
      acc_ff    <= acc_in;
      solve3_ff <= solve3_in;
      clip_ff   <= clip_in;
      sing_ff   <= sing_in;
      step_ff   <= step_in;
      qidx_ff   <= qidx_in;
      dout_ff   <= dout_in;
      o_x_ff    <= o_x_in;
      o_y_ff    <= o_y_in;
      o_z_ff    <= o_z_in;
      o_det_ff  <= o_det_in;
      o_sing_ff <= o_sing_in;
      o_sat_ff  <= o_sat_in;
   end

   // port drive
   assign req_ch.ready     = req_ready;
   assign rsp_ch.valid     = o_valid_ff;
   assign rsp_ch.sol_x     = o_x_ff;
   assign rsp_ch.sol_y     = o_y_ff;
   assign rsp_ch.sol_z     = o_z_ff;
   assign rsp_ch.det_out   = o_det_ff;
   assign rsp_ch.singular  = o_sing_ff;
   assign rsp_ch.saturated = o_sat_ff;

endmodule

### dv/matrix3_linear_solve_test.sv
module matrix3_linear_solve_test;
   import m3ls_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic signed [63:0] WIDE_LIM = 64'sh7FFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic signed [31:0] det;
      logic               singular;
      logic               saturated;
   } solution_type;

   logic clock;
   logic reset;

   m3ls_req_if req_ch ();
   m3ls_rsp_if rsp_ch ();

   matrix3_linear_solve DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // predictor state
   logic signed [31:0] matrix_copy [9];
   bit                 clip_flag;
   solution_type       pending_solutions [$];
   int                 error_count;
   bit                 no_idle;
   int                 rsp_hold;

   // clock
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // wide fixed point helpers
   function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
      logic [127:0] prod;
      logic [63:0]  ma;
      logic [63:0]  mb;
      logic         neg;
      neg  = (a < 0) != (b < 0);
      ma   = (a < 0) ? -a : a;
      mb   = (b < 0) ? -b : b;
      prod = {64'd0, ma} * {64'd0, mb};
      prod = (prod + 128'd32768) >> 16;
      if (prod > {64'd0, WIDE_LIM}) begin
         clip_flag = 1'b1;
         return neg ? -WIDE_LIM : WIDE_LIM;
      end
      return neg ? -$signed(prod[63:0]) : $signed(prod[63:0]);
   endfunction

   function automatic logic signed [63:0] fx_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s > $signed({1'b0, WIDE_LIM})) begin
         clip_flag = 1'b1;
         return WIDE_LIM;
      end
      if (s < -$signed({1'b0, WIDE_LIM})) begin
         clip_flag = 1'b1;
         return -WIDE_LIM;
      end
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] fx_cross(input logic signed [63:0] a,
      input logic signed [63:0] b, input logic signed [63:0] c, input logic signed [63:0] d);
      return fx_add(fx_mul(a, b), -fx_mul(c, d));
   endfunction

   function automatic logic signed [63:0] fx_dot(input logic signed [63:0] a0,
      input logic signed [63:0] a1, input logic signed [63:0] a2,
      input logic signed [63:0] b0, input logic signed [63:0] b1, input logic signed [63:0] b2);
      return fx_add(fx_add(fx_mul(a0, b0), fx_mul(a1, b1)), fx_mul(a2, b2));
   endfunction

   // rounded quotient n / d in Q form, clipped to the word range
   function automatic logic signed [31:0] fx_div(input logic signed [63:0] n,
                                                 input logic signed [63:0] d);
      logic [127:0] num;
      logic [127:0] q;
      logic [127:0] r;
      logic [127:0] ud;
      logic [127:0] lim;
      logic         neg;
      neg = (n < 0) != (d < 0);
      num = {64'd0, ((n < 0) ? -n : n)} << 16;
      ud  = {64'd0, ((d < 0) ? -d : d)};
      q   = num / ud;
      r   = num % ud;
      if (r >= ud - r) q++;
      lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (q > lim) begin
         clip_flag = 1'b1;
         q = lim;
      end
      return neg ? -q[31:0] : q[31:0];
   endfunction

   function automatic solution_type solve_system(input cmd_type cmd,
      input logic signed [31:0] b0, input logic signed [31:0] b1, input logic signed [31:0] b2);
      solution_type s;
      logic signed [63:0] m [9];
      logic signed [63:0] c [9];
      logic signed [63:0] det, n0, n1, n2;
      for (int i = 0; i < 9; i++) m[i] = matrix_copy[i];
      clip_flag = 1'b0;
      n2 = 0;
      if (cmd == CMD_SOLVE3) begin
         c[0] = fx_cross(m[4], m[8], m[5], m[7]);
         c[1] = fx_cross(m[7], m[2], m[1], m[8]);
         c[2] = fx_cross(m[1], m[5], m[4], m[2]);
         c[3] = fx_cross(m[6], m[5], m[3], m[8]);
         c[4] = fx_cross(m[0], m[8], m[6], m[2]);
         c[5] = fx_cross(m[3], m[2], m[0], m[5]);
         c[6] = fx_cross(m[3], m[7], m[6], m[4]);
         c[7] = fx_cross(m[6], m[1], m[0], m[7]);
         c[8] = fx_cross(m[0], m[4], m[3], m[1]);
         det = fx_dot(m[0], m[3], m[6], c[0], c[1], c[2]);
         n0  = fx_dot(c[0], c[1], c[2], b0, b1, b2);
         n1  = fx_dot(c[3], c[4], c[5], b0, b1, b2);
         n2  = fx_dot(c[6], c[7], c[8], b0, b1, b2);
      end else begin
         det = fx_cross(m[0], m[4], m[1], m[3]);
         n0  = fx_cross(m[4], b0, m[1], b1);
         n1  = fx_cross(m[0], b1, m[3], b0);
      end
      s.x = 0; s.y = 0; s.z = 0; s.det = 0;
      s.singular = (det == 0);
      if (!s.singular) begin
         if (det > 64'sh7FFF_FFFF) begin
            clip_flag = 1'b1;
            s.det = 32'h7FFF_FFFF;
         end else if (det < -64'sh8000_0000) begin
            clip_flag = 1'b1;
            s.det = 32'h8000_0000;
         end else begin
            s.det = det[31:0];
         end
         s.x = fx_div(n0, det);
         s.y = fx_div(n1, det);
         if (cmd == CMD_SOLVE3) s.z = fx_div(n2, det);
      end
      s.saturated = clip_flag;
      return s;
   endfunction

   // send one word and update the prediction once it is taken
   task automatic send_word(input cmd_type cmd, input logic [1:0] row,
      input logic signed [31:0] a, input logic signed [31:0] b, input logic signed [31:0] c);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.cmd     <= cmd;
      req_ch.row     <= row;
      req_ch.value_a <= a;
      req_ch.value_b <= b;
      req_ch.value_c <= c;
      do @(posedge clock); while (!req_ch.ready);
      if (cmd == CMD_LOAD && row != ROW_NONE) begin
         matrix_copy[row * 3]     = a;
         matrix_copy[row * 3 + 1] = b;
         matrix_copy[row * 3 + 2] = c;
      end else if (cmd == CMD_SOLVE3 || cmd == CMD_SOLVE2) begin
         pending_solutions.push_back(solve_system(cmd, a, b, c));
      end
   endtask

   function automatic logic signed [31:0] rand_value();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) return 0;
      if (pick < 25) return $urandom;
      if (pick < 35) return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
   endfunction

   task automatic load_matrix(input logic signed [31:0] v [9]);
      for (int r = 0; r < 3; r++)
         send_word(CMD_LOAD, r[1:0], v[r * 3], v[r * 3 + 1], v[r * 3 + 2]);
   endtask

   // edges of the fields, every command, special cases
   task automatic test_directed();
      logic signed [31:0] v [9];
      logic signed [31:0] one;
      one = 32'sh0001_0000;
      send_word(CMD_SOLVE3, 2'd0, one, one, one);
      send_word(CMD_SOLVE2, 2'd3, one, -one, 0);
      v = '{one, 0, 0, 0, one, 0, 0, 0, one};
      load_matrix(v);
      send_word(CMD_SOLVE3, 2'd1, 32'sh7FFF_FFFF, 32'sh8000_0000, -one);
      send_word(CMD_SOLVE2, 2'd2, 32'sh0003_8000, -32'sh0002_4000, 32'h5555_5555);
      send_word(CMD_LOAD, ROW_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(CMD_NOP, 2'd1, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF);
      send_word(CMD_SOLVE3, 2'd0, one, 2 * one, 3 * one);
      v = '{2 * one, one, 0, 4 * one, 2 * one, 0, 0, 0, one};
      load_matrix(v);
      send_word(CMD_SOLVE3, 2'd0, one, one, one);
      send_word(CMD_SOLVE2, 2'd0, one, one, 0);
      v = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
            32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0001, 32'sh8000_0000, 32'sh7FFF_FFFF};
      load_matrix(v);
      send_word(CMD_SOLVE3, 2'd3, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_word(CMD_SOLVE2, 2'd1, 32'sh8000_0000, 32'sh8000_0000, 0);
      v = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
      load_matrix(v);
      send_word(CMD_SOLVE3, 2'd0, 32'sh7FFF_FFFF, -32'sh7FFF_FFFF, 1);
      send_word(CMD_SOLVE2, 2'd0, 1, -1, 0);
   endtask

   // well-formed load-then-solve sequences with random content, plus noise
   task automatic test_random(input int words);
      logic signed [31:0] v [9];
      int sent;
      int pick;
      sent = 0;
      while (sent < words) begin
         if ($urandom_range(0, 9) == 0) no_idle = ~no_idle;
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            for (int i = 0; i < 9; i++) v[i] = rand_value();
            if ($urandom_range(0, 5) == 0) for (int i = 0; i < 3; i++) v[6 + i] = v[i];
            load_matrix(v);
            sent += 3;
         end else if (pick < 40) begin
            send_word(CMD_LOAD, 2'($urandom_range(0, 3)), rand_value(), rand_value(),
                      rand_value());
            sent++;
         end else if (pick < 43) begin
            send_word(CMD_NOP, 2'($urandom), $urandom, $urandom, $urandom);
         end else begin
            send_word(pick < 75 ? CMD_SOLVE3 : CMD_SOLVE2, 2'($urandom),
                      rand_value(), rand_value(), rand_value());
            sent++;
         end
      end
      no_idle = 1'b0;
   endtask

   // long response stall while words keep arriving
   task automatic test_backpressure();
      rsp_hold = 2500;
      no_idle  = 1'b1;
      for (int i = 0; i < 4; i++)
         send_word(i[0] ? CMD_SOLVE2 : CMD_SOLVE3, 2'd0, rand_value(), rand_value(),
                   rand_value());
      no_idle = 1'b0;
   endtask

   // response side readiness
   initial begin
      int n;
      rsp_ch.ready = 1'b0;
      forever begin
         if (rsp_hold > 0) begin
            n = rsp_hold;
            rsp_hold = 0;
         end else begin
            n = no_idle ? 0 : $urandom_range(0, 13);
         end
         if (n > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && !reset));
      end
   end

   // compare each response word with the oldest prediction
   always @(posedge clock) begin
      solution_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_solutions.size() == 0) begin
            report_mismatch("response with no solve outstanding");
         end else begin
            e = pending_solutions.pop_front();
            if (rsp_ch.sol_x !== e.x)
               report_mismatch($sformatf("sol_x %h exp %h", rsp_ch.sol_x, e.x));
            if (rsp_ch.sol_y !== e.y)
               report_mismatch($sformatf("sol_y %h exp %h", rsp_ch.sol_y, e.y));
            if (rsp_ch.sol_z !== e.z)
               report_mismatch($sformatf("sol_z %h exp %h", rsp_ch.sol_z, e.z));
            if (rsp_ch.det_out !== e.det)
               report_mismatch($sformatf("det_out %h exp %h", rsp_ch.det_out, e.det));
            if (rsp_ch.singular !== e.singular)
               report_mismatch($sformatf("singular %b exp %b", rsp_ch.singular, e.singular));
            if (rsp_ch.saturated !== e.saturated)
               report_mismatch($sformatf("saturated %b exp %b", rsp_ch.saturated,
                                         e.saturated));
         end
      end
   end

   // run limit
   initial begin
      #60ms;
      $display("matrix3_linear_solve_test failed");
      $finish;
   end

   initial begin
      int drain;
      error_count = 0;
      no_idle     = 1'b0;
      rsp_hold    = 0;
      for (int i = 0; i < 9; i++) matrix_copy[i] = 0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.cmd     = CMD_LOAD;
      req_ch.row     = 2'd0;
      req_ch.value_a = 0;
      req_ch.value_b = 0;
      req_ch.value_c = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(450);
      test_backpressure();
      test_random(450);
      req_ch.valid <= 1'b0;
      drain = 0;
      while (pending_solutions.size() != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      if (pending_solutions.size() != 0)
         report_mismatch("solves still outstanding at end");
      repeat (500) @(posedge clock);
      if (error_count == 0) begin
         $display("matrix3_linear_solve_test passed");
      end else begin
         $display("matrix3_linear_solve_test failed");
      end
      $finish;
   end

endmodule
